/* rtl/core/rect_to_polar_converter_core_macros.svh */
// assertion macros for the rect to polar converter core
// used by rect_to_polar_converter_core.sv, expects clk and rst_n in scope
`ifndef RECT_TO_POLAR_CONVERTER_CORE_MACROS_SVH
`define RECT_TO_POLAR_CONVERTER_CORE_MACROS_SVH

// property that must hold at every edge out of reset
`define RTP_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after a trigger
`define RTP_CHECK_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rtp_pkg.sv */
// shared constants, arctangent table and stage record for the polar converter
// no dependencies
`timescale 1ns / 1ps

package rtp_pkg;

    localparam int ITERATIONS   = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_STEPS = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;
    localparam int SQRT_STEPS   = 16;
    localparam int PIPE_STAGES  = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int SCALE    = 16;
    localparam int XY_W     = 34;
    localparam int Z_W      = 28;
    localparam int SQ_W     = 32;
    localparam int ANG_FRAC = 24;
    localparam int OUT_FRAC = 13;

    localparam logic signed [Z_W-1:0]   PI_ACC  = 28'sd52707179;
    localparam logic signed [OUT_W-1:0] PI_Q13  = 16'sd25736;
    localparam logic [OUT_W-1:0]        MOD_MAX = 16'd46341;

    // atan(2^-i) in units of 2^-24
    localparam logic [23:0] ATAN_LUT [ATAN_ENTRIES] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214,  24'd524117,  24'd262123,  24'd131069,
        24'd65536,    24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,
        24'd256,      24'd128,     24'd64,      24'd32,
        24'd16,       24'd8,       24'd4,       24'd2
    };

    typedef struct packed {
        logic [SQ_W-1:0]        rem;
        logic [SQ_W-1:0]        root;
        logic signed [XY_W-1:0] cx;
        logic signed [XY_W-1:0] cy;
        logic signed [Z_W-1:0]  cz;
        logic                   on_axis;
        logic                   x_neg;
    } stage_t;

endpackage

/* rtl/core/rtp_prep.sv */
// front end: squares, sum of squares and half-turn pre-rotation, two register stages
// depends on rtp_pkg
`timescale 1ns / 1ps

module rtp_prep
    import rtp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  x_value,
    input  logic signed [IN_W-1:0]  y_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output stage_t                  out_data
);

    localparam int EXT_W = XY_W - IN_W - SCALE;

    // stage a
    logic                   va_reg;
    logic [SQ_W-2:0]        sqx_reg, sqx_next;
    logic [SQ_W-2:0]        sqy_reg, sqy_next;
    logic signed [XY_W-1:0] cx_reg, cx_next;
    logic signed [XY_W-1:0] cy_reg, cy_next;
    logic signed [Z_W-1:0]  cz_reg, cz_next;
    logic                   axis_reg, axis_next;
    logic                   neg_reg, neg_next;
    // stage b
    logic                   vb_reg;
    stage_t                 data_reg, data_next;

    logic                   ready_a, ready_b;
    logic signed [2*IN_W-1:0] x_prod, y_prod;
    logic signed [XY_W-1:0] x_ext, y_ext;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_comb
    begin
        x_prod    = x_value * x_value;
        y_prod    = y_value * y_value;
        sqx_next  = x_prod[SQ_W-2:0];
        sqy_next  = y_prod[SQ_W-2:0];
        x_ext     = {{EXT_W{x_value[IN_W-1]}}, x_value, {SCALE{1'b0}}};
        y_ext     = {{EXT_W{y_value[IN_W-1]}}, y_value, {SCALE{1'b0}}};
        axis_next = (y_value == '0);
        neg_next  = x_value[IN_W-1];
        if (x_value[IN_W-1])
        begin
            // half-turn so the vector lies in the right half plane
            cx_next = -x_ext;
            cy_next = -y_ext;
            cz_next = (y_value > 0) ? PI_ACC : -PI_ACC;
        end
        else
        begin
            cx_next = x_ext;
            cy_next = y_ext;
            cz_next = '0;
        end
    end

    always_comb
    begin
        data_next.rem     = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        data_next.root    = '0;
        data_next.cx      = cx_reg;
        data_next.cy      = cy_reg;
        data_next.cz      = cz_reg;
        data_next.on_axis = axis_reg;
        data_next.x_neg   = neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            sqx_reg  <= sqx_next;
            sqy_reg  <= sqy_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            cz_reg   <= cz_next;
            axis_reg <= axis_next;
            neg_reg  <= neg_next;
        end
        if (ready_b && va_reg)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/rtp_pipe.sv */
// iteration pipeline: one square-root digit and one cordic micro-rotation per stage
// depends on rtp_pkg
`timescale 1ns / 1ps

module rtp_pipe
    import rtp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  stage_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output stage_t out_data
);

    stage_t st_reg  [PIPE_STAGES];
    stage_t st_next [PIPE_STAGES];
    logic   v_reg   [PIPE_STAGES];
    logic   src_v   [PIPE_STAGES];
    stage_t src_d   [PIPE_STAGES];
    logic   rdy     [PIPE_STAGES];
    logic   dn_rdy  [PIPE_STAGES];

    for (genvar k = 0; k < PIPE_STAGES; k++)
    begin : g_stage
        logic [SQ_W-1:0]        rem_nx, root_nx;
        logic signed [XY_W-1:0] cx_nx, cy_nx;
        logic signed [Z_W-1:0]  cz_nx;

        if (k == 0)
        begin : g_first
            assign src_d[k] = in_data;
            assign src_v[k] = in_valid;
        end
        else
        begin : g_rest
            assign src_d[k] = st_reg[k-1];
            assign src_v[k] = v_reg[k-1];
        end

        if (k == PIPE_STAGES - 1)
        begin : g_last
            assign dn_rdy[k] = out_ready;
        end
        else
        begin : g_mid
            assign dn_rdy[k] = rdy[k+1];
        end

        assign rdy[k] = !v_reg[k] || dn_rdy[k];

        // restoring square root, one result bit
        if (k < SQRT_STEPS)
        begin : g_sqrt
            localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            logic [SQ_W:0] trial;
            logic          take;

            assign trial   = {1'b0, src_d[k].root} + {1'b0, SQ_BIT};
            assign take    = ({1'b0, src_d[k].rem} >= trial);
            assign rem_nx  = take ? (src_d[k].rem - trial[SQ_W-1:0]) : src_d[k].rem;
            assign root_nx = take ? ((src_d[k].root >> 1) + SQ_BIT) : (src_d[k].root >> 1);
        end
        else
        begin : g_sqrt_idle
            assign rem_nx  = src_d[k].rem;
            assign root_nx = src_d[k].root;
        end

        // vectoring micro-rotation, drives y towards zero
        if (k < CORDIC_STEPS)
        begin : g_cordic
            logic signed [XY_W-1:0] xs, ys;
            logic signed [Z_W-1:0]  step_ang;
            logic                   y_pos;

            assign xs       = $signed(src_d[k].cx) >>> k;
            assign ys       = $signed(src_d[k].cy) >>> k;
            assign step_ang = $signed(Z_W'(ATAN_LUT[k]));
            assign y_pos    = !src_d[k].cy[XY_W-1] && (src_d[k].cy != '0);
            assign cx_nx    = y_pos ? (src_d[k].cx + ys) : (src_d[k].cx - ys);
            assign cy_nx    = y_pos ? (src_d[k].cy - xs) : (src_d[k].cy + xs);
            assign cz_nx    = y_pos ? (src_d[k].cz + step_ang) : (src_d[k].cz - step_ang);
        end
        else
        begin : g_cordic_idle
            assign cx_nx = src_d[k].cx;
            assign cy_nx = src_d[k].cy;
            assign cz_nx = src_d[k].cz;
        end

        always_comb
        begin
            st_next[k]         = src_d[k];
            st_next[k].rem     = rem_nx;
            st_next[k].root    = root_nx;
            st_next[k].cx      = cx_nx;
            st_next[k].cy      = cy_nx;
            st_next[k].cz      = cz_nx;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= src_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_v[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[PIPE_STAGES-1];
    assign out_data  = st_reg[PIPE_STAGES-1];

endmodule

/* rtl/core/rtp_final.sv */
// back end: modulus rounding, angle rounding and clamp, real-axis cases, output register
// depends on rtp_pkg
`timescale 1ns / 1ps

module rtp_final
    import rtp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  stage_t                  in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_W-1:0]        modulus,
    output logic signed [OUT_W-1:0] angle
);

    localparam int DROP = ANG_FRAC - OUT_FRAC;
    localparam logic signed [Z_W:0] ROUND_HALF = (Z_W + 1)'(1) <<< (DROP - 1);
    localparam logic signed [Z_W:0] PI_WIDE    = (Z_W + 1)'(PI_Q13);

    logic                    v_reg;
    logic [OUT_W-1:0]        mod_reg, mod_next;
    logic signed [OUT_W-1:0] ang_reg, ang_next;
    logic                    ready;
    logic [SQ_W-1:0]         root_rnd;
    logic signed [Z_W:0]     z_sum, z_shr, z_clip;

    assign ready    = !v_reg || out_ready;
    assign in_ready = ready;

    always_comb
    begin
        root_rnd = (in_data.rem > in_data.root) ? (in_data.root + SQ_W'(1)) : in_data.root;
        mod_next = root_rnd[OUT_W-1:0];

        z_sum = {in_data.cz[Z_W-1], in_data.cz} + ROUND_HALF;
        z_shr = z_sum >>> DROP;
        if (z_shr > PI_WIDE)
        begin
            z_clip = PI_WIDE;
        end
        else if (z_shr < -PI_WIDE)
        begin
            z_clip = -PI_WIDE;
        end
        else
        begin
            z_clip = z_shr;
        end

        // real axis: angle is exact, pi on the negative side
        if (in_data.on_axis)
        begin
            ang_next = in_data.x_neg ? PI_Q13 : '0;
        end
        else
        begin
            ang_next = z_clip[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            mod_reg <= mod_next;
            ang_reg <= ang_next;
        end
    end

    assign out_valid = v_reg;
    assign modulus   = mod_reg;
    assign angle     = ang_reg;

endmodule

/* rtl/core/rect_to_polar_converter_core.sv */
// top level of the cartesian to polar converter: front end, iteration pipeline, back end
// depends on rtp_pkg, rtp_prep, rtp_pipe, rtp_final and the core macro header
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_ready | x_value, y_value (signed 16 bit)
//  output   | out_valid/out_ready | modulus (unsigned 16), angle (signed Q3.13)
//
// one request enters per clock while out_ready keeps the output moving; the pipeline depth is
// set by the 16 square-root digits or the cordic steps, whichever is longer
// reset (rst_n, asynchronous) clears only the valid bits; no state is kept between requests
// a stall at the output holds each stage whose successor is full; bubbles still move on
`timescale 1ns / 1ps

`include "rect_to_polar_converter_core_macros.svh"

module rect_to_polar_converter_core
    import rtp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  x_value,
    input  logic signed [IN_W-1:0]  y_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_W-1:0]        modulus,
    output logic signed [OUT_W-1:0] angle
);

    // front end to iteration pipeline
    logic   prep_valid;
    logic   prep_ready;
    stage_t prep_data;

    // iteration pipeline to back end
    logic   pipe_valid;
    logic   pipe_ready;
    stage_t pipe_data;

    // squares, their sum, and the half-turn pre-rotation for negative x
    rtp_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_value   (x_value),
        .y_value   (y_value),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    // square root digits and cordic micro-rotations run side by side, stage by stage
    rtp_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_data  (pipe_data)
    );

    // rounding, clamp to +-pi, real-axis cases; holds the finished result
    rtp_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_valid),
        .in_ready  (pipe_ready),
        .in_data   (pipe_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .modulus   (modulus),
        .angle     (angle)
    );

    // an empty output register means every stage behind it can move
    `RTP_CHECK(a_ready_when_drained, !out_valid |-> in_ready, "input stalled with empty output")

    // results stay in range
    `RTP_CHECK(a_result_range, out_valid |-> (modulus <= MOD_MAX && $signed(angle) <= PI_Q13 && $signed(angle) >= -PI_Q13), "result out of range")

    // only the origin rounds to modulus zero, and it has angle zero
    `RTP_CHECK(a_origin_angle, (out_valid && modulus == '0) |-> (angle == '0), "origin angle not zero")

    // a finished result that is not taken is still offered next cycle
    `RTP_CHECK_NEXT(a_result_kept, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule
